>>> rtl/brcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brcf_pkg: shared types and constants for the Baudot RTTY character framer
// Holds the ITA2 lookup, the frame queue entry and the line timing codes.
// ----------------------------------------------------------------------------
package brcf_pkg;

   localparam int PREAMBLE_FRAMES_DEFAULT = 4;
   localparam int QUEUE_DEPTH_DEFAULT     = 4;
   localparam int MAX_PRE_PER_INPUT       = 4;
   localparam int SEGS_PER_FRAME          = 7;

   localparam logic [4:0] CODE_LTRS  = 5'h1F;
   localparam logic [4:0] CODE_FIGS  = 5'h1B;
   localparam logic [4:0] CODE_SPACE = 5'h04;
   localparam logic [7:0] CHAR_ETX   = 8'h03;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [7:0] CASE_FOLD  = 8'h20;

   localparam logic [2:0] HALF_DATA       = 3'd2;
   localparam logic [2:0] HALF_STOP_SHORT = 3'd3;
   localparam logic [2:0] HALF_STOP_LONG  = 3'd4;

   // configuration register indexes
   localparam logic CSR_SHORT_STOP       = 1'b0;
   localparam logic CSR_REVERSE_POLARITY = 1'b1;

   typedef struct packed {
      logic       last;
      logic [4:0] code;
   } frame_type;

   typedef struct packed {
      logic short_stop;
      logic reverse_polarity;
   } cfg_type;

   typedef struct packed {
      logic       hit;
      logic       fig;
      logic [4:0] code;
   } enc_type;

   // First-match ITA2 lookup of an upper-case byte: letters before figures
   function automatic enc_type ita2_encode(input logic [7:0] c);
      enc_type e;
      e.hit  = 1'b1;
      e.fig  = 1'b0;
      e.code = CODE_SPACE;
      case (c)
         8'h20: e.code = 5'd4;
         8'h0A: e.code = 5'd2;
         8'h0D: e.code = 5'd8;
         "E":   e.code = 5'd1;
         "A":   e.code = 5'd3;
         "S":   e.code = 5'd5;
         "I":   e.code = 5'd6;
         "U":   e.code = 5'd7;
         "D":   e.code = 5'd9;
         "R":   e.code = 5'd10;
         "J":   e.code = 5'd11;
         "N":   e.code = 5'd12;
         "F":   e.code = 5'd13;
         "C":   e.code = 5'd14;
         "K":   e.code = 5'd15;
         "T":   e.code = 5'd16;
         "Z":   e.code = 5'd17;
         "L":   e.code = 5'd18;
         "W":   e.code = 5'd19;
         "H":   e.code = 5'd20;
         "Y":   e.code = 5'd21;
         "P":   e.code = 5'd22;
         "Q":   e.code = 5'd23;
         "O":   e.code = 5'd24;
         "B":   e.code = 5'd25;
         "G":   e.code = 5'd26;
         "M":   e.code = 5'd28;
         "X":   e.code = 5'd29;
         "V":   e.code = 5'd30;
         "3":   begin e.fig = 1'b1; e.code = 5'd1;  end
         "-":   begin e.fig = 1'b1; e.code = 5'd3;  end
         8'h07: begin e.fig = 1'b1; e.code = 5'd5;  end
         "8":   begin e.fig = 1'b1; e.code = 5'd6;  end
         "7":   begin e.fig = 1'b1; e.code = 5'd7;  end
         "$":   begin e.fig = 1'b1; e.code = 5'd9;  end
         "4":   begin e.fig = 1'b1; e.code = 5'd10; end
         8'h27: begin e.fig = 1'b1; e.code = 5'd11; end
         ",":   begin e.fig = 1'b1; e.code = 5'd12; end
         "!":   begin e.fig = 1'b1; e.code = 5'd13; end
         ":":   begin e.fig = 1'b1; e.code = 5'd14; end
         "(":   begin e.fig = 1'b1; e.code = 5'd15; end
         "5":   begin e.fig = 1'b1; e.code = 5'd16; end
         8'h22: begin e.fig = 1'b1; e.code = 5'd17; end
         ")":   begin e.fig = 1'b1; e.code = 5'd18; end
         "2":   begin e.fig = 1'b1; e.code = 5'd19; end
         "#":   begin e.fig = 1'b1; e.code = 5'd20; end
         "6":   begin e.fig = 1'b1; e.code = 5'd21; end
         "0":   begin e.fig = 1'b1; e.code = 5'd22; end
         "1":   begin e.fig = 1'b1; e.code = 5'd23; end
         "9":   begin e.fig = 1'b1; e.code = 5'd24; end
         "?":   begin e.fig = 1'b1; e.code = 5'd25; end
         "&":   begin e.fig = 1'b1; e.code = 5'd26; end
         ".":   begin e.fig = 1'b1; e.code = 5'd28; end
         "/":   begin e.fig = 1'b1; e.code = 5'd29; end
         ";":   begin e.fig = 1'b1; e.code = 5'd30; end
         default: e.hit = 1'b0;
      endcase
      return e;
   endfunction

endpackage

>>> rtl/brcf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brcf_front: character classifier and frame scheduler
// Accepts characters and idle events, tracks case and owed preamble, and
// pushes one frame code per cycle into the frame queue while it is not full.
// ----------------------------------------------------------------------------
module brcf_front #(
   parameter int PREAMBLE_FRAMES = brcf_pkg::PREAMBLE_FRAMES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                kind,
   input  logic [7:0]          char_code,
   input  logic                q_full,
   output logic                q_push,
   output brcf_pkg::frame_type q_entry
);
   import brcf_pkg::*;

   localparam logic [2:0] PreLoad = 3'(PREAMBLE_FRAMES);
   localparam logic [2:0] PreMax  = 3'(MAX_PRE_PER_INPUT);

   logic       figures_case_ff, figures_case_in;
   logic [2:0] preamble_left_ff, preamble_left_in;
   logic       busy_ff, busy_in;
   logic [2:0] pre_cnt_ff, pre_cnt_in;
   logic       shift_ff, shift_in;
   logic [4:0] shift_code_ff, shift_code_in;
   logic [4:0] main_code_ff, main_code_in;

   logic       accept, is_char, final_push;
   logic [2:0] pre_take;
   logic       cur_case, new_case;
   logic [7:0] folded;
   enc_type    enc;

   assign is_char = kind && (char_code != CHAR_NUL);
   assign pre_take = (preamble_left_ff > PreMax) ? PreMax : preamble_left_ff;
   assign cur_case = (pre_take != 3'd0) ? 1'b0 : figures_case_ff;
   assign folded = (char_code >= CHAR_LC_A && char_code <= CHAR_LC_Z) ?
                   (char_code - CASE_FOLD) : char_code;
   assign enc = ita2_encode(folded);
   // unknown bytes send a space in whatever case is current
   assign new_case = enc.hit ? enc.fig : cur_case;

   always_comb begin
      q_entry.last = 1'b0;
      q_entry.code = CODE_LTRS;
      if (pre_cnt_ff == 3'd0) begin
         if (shift_ff) begin
            q_entry.code = shift_code_ff;
         end else begin
            q_entry.code = main_code_ff;
            q_entry.last = 1'b1;
         end
      end
   end

   assign q_push     = busy_ff && !q_full;
   assign final_push = q_push && q_entry.last;
   assign req_tready = !busy_ff || final_push;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      figures_case_in  = figures_case_ff;
      preamble_left_in = preamble_left_ff;
      busy_in          = busy_ff;
      pre_cnt_in       = pre_cnt_ff;
      shift_in         = shift_ff;
      shift_code_in    = shift_code_ff;
      main_code_in     = main_code_ff;
      // drain the current job one frame per transfer
      if (q_push) begin
         if (pre_cnt_ff != 3'd0) begin
            pre_cnt_in = pre_cnt_ff - 3'd1;
         end else if (shift_ff) begin
            shift_in = 1'b0;
         end else begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         if (!is_char) begin
            preamble_left_in = PreLoad;
         end else begin
            preamble_left_in = preamble_left_ff - pre_take;
            busy_in          = 1'b1;
            pre_cnt_in       = pre_take;
            if (char_code == CHAR_ETX) begin
               shift_in        = 1'b0;
               shift_code_in   = CODE_LTRS;
               main_code_in    = CODE_LTRS;
               figures_case_in = 1'b0;
            end else begin
               shift_in        = (new_case != cur_case);
               shift_code_in   = new_case ? CODE_FIGS : CODE_LTRS;
               main_code_in    = enc.hit ? enc.code : CODE_SPACE;
               figures_case_in = new_case;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         figures_case_ff  <= 1'b1;
         preamble_left_ff <= 3'd0;
         busy_ff          <= 1'b0;
         pre_cnt_ff       <= 3'd0;
         shift_ff         <= 1'b0;
      end else begin
         figures_case_ff  <= figures_case_in;
         preamble_left_ff <= preamble_left_in;
         busy_ff          <= busy_in;
         pre_cnt_ff       <= pre_cnt_in;
         shift_ff         <= shift_in;
      end
      shift_code_ff <= shift_code_in;
      main_code_ff  <= main_code_in;
   end

   a_char_starts_job: assert property (@(posedge clock) disable iff (reset)
      (accept && is_char) |=> busy_ff)
      else $error("accepted character did not start a frame job");

   a_idle_owes_preamble: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_char) |=> (preamble_left_ff == PreLoad))
      else $error("idle event did not arm the preamble");

endmodule

>>> rtl/brcf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brcf_queue: frame queue between scheduler and line serializer
// Small first-in first-out buffer of frame codes with end-of-input marks.
// ----------------------------------------------------------------------------
module brcf_queue #(
   parameter int DEPTH = brcf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  brcf_pkg::frame_type push_entry,
   input  logic                pop,
   output brcf_pkg::frame_type head_entry,
   output logic                full,
   output logic                empty
);
   import brcf_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   frame_type       mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == CntFull);
   assign empty      = (count_ff == '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("frame queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("frame queue underflow");

endmodule

>>> rtl/brcf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brcf_back: line segment serializer
// Turns each queued frame into start, five data and stop segments.
// ----------------------------------------------------------------------------
module brcf_back (
   input  logic                clock,
   input  logic                reset,
   input  brcf_pkg::cfg_type   cfg,
   input  logic                q_empty,
   input  brcf_pkg::frame_type q_head,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,  // [0] pin_level, [3:1] half_bits, [8:4] frame_code
   output logic                rsp_tlast   // last
);
   import brcf_pkg::*;

   localparam logic [2:0] LastSeg = 3'(SEGS_PER_FRAME - 1);

   logic       active_ff, active_in;
   logic [2:0] seg_ff, seg_in;
   frame_type  frame_ff, frame_in;

   logic       done, mark;
   logic [2:0] halves;
   logic [2:0] bit_sel;

   assign done    = active_ff && rsp_tready && (seg_ff == LastSeg);
   assign q_pop   = !q_empty && (!active_ff || done);
   assign bit_sel = seg_ff - 3'd1;

   always_comb begin
      mark   = 1'b0;
      halves = HALF_DATA;
      if (seg_ff == LastSeg) begin
         mark   = 1'b1;
         halves = cfg.short_stop ? HALF_STOP_SHORT : HALF_STOP_LONG;
      end else if (seg_ff != 3'd0) begin
         mark = frame_ff.code[bit_sel];
      end
   end

   assign rsp_tvalid = active_ff;
   assign rsp_tdata  = {7'd0, frame_ff.code, halves,
                        cfg.reverse_polarity ? mark : !mark};
   assign rsp_tlast  = frame_ff.last && (seg_ff == LastSeg);

   always_comb begin
      active_in = active_ff;
      seg_in    = seg_ff;
      frame_in  = frame_ff;
      if (active_ff && rsp_tready) begin
         seg_in = seg_ff + 3'd1;
      end
      if (done) begin
         active_in = 1'b0;
      end
      // load the next frame as soon as the stop segment is taken
      if (q_pop) begin
         active_in = 1'b1;
         seg_in    = 3'd0;
         frame_in  = q_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         seg_ff    <= 3'd0;
      end else begin
         active_ff <= active_in;
         seg_ff    <= seg_in;
      end
      frame_ff <= frame_in;
   end

   a_seg_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (seg_ff <= LastSeg))
      else $error("segment counter past stop segment");

   a_frame_not_cut: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && seg_ff != LastSeg) |=> rsp_tvalid)
      else $error("frame dropped before its stop segment");

endmodule

>>> rtl/baudot_rtty_character_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baudot_rtty_character_framer: ITA2 Baudot RTTY character framer
// Encodes ASCII into ITA2 frames and emits them as timed line segments.
// ----------------------------------------------------------------------------
// Each transfer on req carries a character (tuser = 1) or an idle event
// (tuser = 0, or character 0). A character yields one frame, plus a LTRS or
// FIGS frame on a case change and up to four owed preamble LTRS frames; an
// idle event yields nothing and arms the preamble. Every frame leaves on rsp
// as seven segments, one per cycle while rsp_tready is high, paced by the
// serializer's segment counter; a character yields one to six frames. The
// scheduler queues frames at one per cycle while not full and takes the next
// input as soon as its last frame is queued. No clearing after reset.
module baudot_rtty_character_framer #(
   parameter int PREAMBLE_FRAMES = brcf_pkg::PREAMBLE_FRAMES_DEFAULT,
   parameter int QUEUE_DEPTH     = brcf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] pin_level, [3:1] half_bits, [8:4] frame_code
   output logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic        csr_wdata
);
   import brcf_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      q_push, q_pop, q_full, q_empty;
   frame_type q_entry, q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SHORT_STOP:       cfg_in.short_stop       = csr_wdata;
            CSR_REVERSE_POLARITY: cfg_in.reverse_polarity = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   brcf_front #(
      .PREAMBLE_FRAMES(PREAMBLE_FRAMES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .kind       (req_tuser),
      .char_code  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   brcf_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head_entry (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   brcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
